// ===== rtl/hex_world_to_cell_and_chunk_defines.svh =====
// assertion macros for the hex cell lookup checker
`ifndef HEX_WORLD_TO_CELL_AND_CHUNK_DEFINES_SVH
`define HEX_WORLD_TO_CELL_AND_CHUNK_DEFINES_SVH

// same-cycle implication
`define HWCC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hwcc check failed");

// next-cycle implication
`define HWCC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hwcc check failed");

`endif

// ===== rtl/hwcc_pkg.sv =====
// shared constants, types and helper functions of the hex cell lookup
`default_nettype none
package hwcc_pkg;

	localparam int POS_FRAC = 8;
	localparam int COEF_FRAC = 20;
	localparam int SUM_FRAC = POS_FRAC + COEF_FRAC;
	localparam int DIV_STEPS = 18;

	localparam logic [13:0] COEF_Q = 14'd13981;
	localparam logic [12:0] COEF_RX = 13'd6991;
	localparam logic [13:0] COEF_RY = 14'd12108;

	localparam logic signed [32:0] LAYER_HALF = 33'sd12800;
	localparam logic signed [23:0] LAYER_BIAS = 24'sd6553600;
	localparam logic [24:0] LAYER_RECIP = 25'd21474837;
	localparam logic signed [20:0] LAYER_OFS = 21'sd262144;

	localparam logic [12:0] CHUNK_RESET = 13'd16;
	localparam logic [2:0] ADDR_CHUNK_SIZE = 3'd0;

	typedef struct packed {
		logic signed [20:0] val;
		logic [27:0] err;
	} rnd_t;

	typedef struct packed {
		logic [12:0] rem;
		logic [17:0] nq;
	} dstep_t;

	typedef struct packed {
		logic signed [18:0] cell_q;
		logic signed [18:0] cell_r;
		logic signed [17:0] layer;
		logic [12:0] dsr;
		logic neg_q;
		logic neg_r;
		logic [12:0] q_rem;
		logic [12:0] r_rem;
		logic [17:0] q_nq;
		logic [17:0] r_nq;
	} div_item_t;

	function automatic rnd_t round_half_up(input logic signed [48:0] v);
		logic signed [48:0] t;
		logic [27:0] frac;
		rnd_t res;
		t = v + 49'sd134217728;
		frac = t[27:0];
		res.val = t[48:28];
		res.err = frac[27] ? {1'b0, frac[26:0]} : 28'd134217728 - frac;
		return res;
	endfunction

	function automatic logic signed [18:0] sat19(input logic signed [21:0] v);
		if (v > 22'sd262143) begin
			return 19'sd262143;
		end else if (v < -22'sd262144) begin
			return -19'sd262144;
		end
		return v[18:0];
	endfunction

	function automatic logic signed [17:0] sat18(input logic signed [20:0] v);
		if (v > 21'sd131071) begin
			return 18'sd131071;
		end else if (v < -21'sd131072) begin
			return -18'sd131072;
		end
		return v[17:0];
	endfunction

	function automatic dstep_t div_step(input logic [12:0] rem, input logic [17:0] nq,
			input logic [12:0] dsr);
		logic [13:0] t;
		logic [13:0] d;
		logic ge;
		dstep_t res;
		t = {rem, nq[17]};
		d = t - {1'b0, dsr};
		ge = t >= {1'b0, dsr};
		res.rem = ge ? d[12:0] : t[12:0];
		res.nq = {nq[16:0], ge};
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hex_world_to_cell_and_chunk.sv =====
// top level: world position to flat-top hex cell, layer and chunk
// pipeline: 4 front stages followed by 18 divider cells, from input item to result item
// throughput: one item per cycle unless stalled, one quotient bit per divider cell
// a stalled output backs up stage by stage, bubbles in between are still filled
// reset clears all stage valid bits and sets chunk_size to 16
`default_nettype none
module hex_world_to_cell_and_chunk (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [95:0]  s_axis_tdata,   // world_x, world_y, world_z
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [95:0]       m_axis_tdata,   // cell_q, cell_r, layer, chunk_x, chunk_y, pad
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import hwcc_pkg::*;

	logic [12:0] chunk_size_q;
	logic [DIV_STEPS:0] vld;
	logic [DIV_STEPS:0] rdy;
	div_item_t items [DIV_STEPS+1];
	div_item_t last;
	logic [18:0] cx, cy;

	assign pready = 1'b1;
	assign prdata = {19'd0, chunk_size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_CHUNK_SIZE) begin
			chunk_size_q <= pwdata[12:0];
		end
	end

	hwcc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.world_x    (s_axis_tdata[31:0]),
		.world_y    (s_axis_tdata[63:32]),
		.world_z    (s_axis_tdata[95:64]),
		.chunk_size (chunk_size_q),
		.out_valid  (vld[0]),
		.out_ready  (rdy[0]),
		.out_item   (items[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		hwcc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[i]),
			.in_ready  (rdy[i]),
			.in_item   (items[i]),
			.out_valid (vld[i+1]),
			.out_ready (rdy[i+1]),
			.out_item  (items[i+1])
		);
	end

	assign rdy[DIV_STEPS] = m_axis_tready;
	assign last = items[DIV_STEPS];
	assign cx = last.neg_q ? ~{1'b0, last.q_nq} : {1'b0, last.q_nq};
	assign cy = last.neg_r ? ~{1'b0, last.r_nq} : {1'b0, last.r_nq};

	assign m_axis_tvalid = vld[DIV_STEPS];
	assign m_axis_tdata = {2'b00, cy, cx, last.layer, last.cell_r, last.cell_q};

endmodule
`default_nettype wire

// ===== rtl/hwcc_front.sv =====
// front pipeline: axial products, cube rounding, layer and divider setup
`default_nettype none
module hwcc_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [31:0]       world_x,
	input  wire logic signed [31:0]       world_y,
	input  wire logic signed [31:0]       world_z,
	input  wire logic [12:0]              chunk_size,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output hwcc_pkg::div_item_t           out_item
);
	import hwcc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic signed [46:0] pq_s1, pry_s1;
	logic signed [45:0] prx_s1;
	logic [23:0] lu_s1;
	logic signed [48:0] qv_s2, rv_s2, sv_s2;
	logic [48:0] lm_s2;
	rnd_t qr_s3, rr_s3, sr_s3;
	logic signed [17:0] layer_s3;
	div_item_t item_s4;

	logic signed [32:0] zz;
	logic signed [22:0] zsh;
	logic signed [23:0] lu;
	logic signed [20:0] lq;
	logic signed [21:0] q_fix, r_fix;
	logic signed [18:0] q_sel, r_sel;
	logic qe_max, re_max;

	assign rdy_s4 = !v_s4 || out_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign zz = {world_z[31], world_z} + LAYER_HALF;
	assign zsh = zz[32:10];
	assign lu = {zsh[22], zsh} + LAYER_BIAS;
	assign lq = $signed({1'b0, lm_s2[48:29]}) - LAYER_OFS;

	assign qe_max = (qr_s3.err > rr_s3.err) && (qr_s3.err > sr_s3.err);
	assign re_max = rr_s3.err > sr_s3.err;
	assign q_fix = -{rr_s3.val[20], rr_s3.val} - {sr_s3.val[20], sr_s3.val};
	assign r_fix = -{qr_s3.val[20], qr_s3.val} - {sr_s3.val[20], sr_s3.val};

	always_comb begin
		q_sel = sat19({qr_s3.val[20], qr_s3.val});
		r_sel = sat19({rr_s3.val[20], rr_s3.val});
		if (qe_max) begin
			q_sel = sat19(q_fix);
		end else if (re_max) begin
			r_sel = sat19(r_fix);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			pq_s1 <= world_x * $signed({1'b0, COEF_Q});
			pry_s1 <= world_y * $signed({1'b0, COEF_RY});
			prx_s1 <= world_x * $signed({1'b0, COEF_RX});
			lu_s1 <= lu;
		end
		if (rdy_s2) begin
			qv_s2 <= 49'(pq_s1);
			rv_s2 <= 49'(pry_s1) - 49'(prx_s1);
			sv_s2 <= 49'(prx_s1) - 49'(pq_s1) - 49'(pry_s1);
			lm_s2 <= lu_s1 * LAYER_RECIP;
		end
		if (rdy_s3) begin
			qr_s3 <= round_half_up(qv_s2);
			rr_s3 <= round_half_up(rv_s2);
			sr_s3 <= round_half_up(sv_s2);
			layer_s3 <= sat18(lq);
		end
		if (rdy_s4) begin
			item_s4.cell_q <= q_sel;
			item_s4.cell_r <= r_sel;
			item_s4.layer <= layer_s3;
			item_s4.dsr <= (chunk_size == 13'd0) ? 13'd1 : chunk_size;
			item_s4.neg_q <= q_sel[18];
			item_s4.neg_r <= r_sel[18];
			item_s4.q_rem <= 13'd0;
			item_s4.r_rem <= 13'd0;
			item_s4.q_nq <= q_sel[18] ? ~q_sel[17:0] : q_sel[17:0];
			item_s4.r_nq <= r_sel[18] ? ~r_sel[17:0] : r_sel[17:0];
		end
	end

	assign out_valid = v_s4;
	assign out_item = item_s4;

endmodule
`default_nettype wire

// ===== rtl/hwcc_div_cell.sv =====
// one restoring division step on both chunk lanes, registered
`default_nettype none
module hwcc_div_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire hwcc_pkg::div_item_t      in_item,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output hwcc_pkg::div_item_t           out_item
);
	import hwcc_pkg::*;

	logic valid_q;
	div_item_t item_q;
	div_item_t next_item;
	dstep_t q_step, r_step;

	assign in_ready = !valid_q || out_ready;
	assign q_step = div_step(in_item.q_rem, in_item.q_nq, in_item.dsr);
	assign r_step = div_step(in_item.r_rem, in_item.r_nq, in_item.dsr);

	always_comb begin
		next_item = in_item;
		next_item.q_rem = q_step.rem;
		next_item.q_nq = q_step.nq;
		next_item.r_rem = r_step.rem;
		next_item.r_nq = r_step.nq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			item_q <= next_item;
		end
	end

	assign out_valid = valid_q;
	assign out_item = item_q;

endmodule
`default_nettype wire

// ===== rtl/hwcc_checker.sv =====
// port-level checker for the hex cell lookup, bound to the top level
`default_nettype none
`include "hex_world_to_cell_and_chunk_defines.svh"
module hwcc_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [95:0]  m_axis_tdata,
	input wire logic         psel,
	input wire logic         penable,
	input wire logic         pwrite,
	input wire logic         pready,
	input wire logic [2:0]   paddr,
	input wire logic [31:0]  pwdata,
	input wire logic [31:0]  prdata
);

	`HWCC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	`HWCC_ASSERT_NXT(a_cfg_readback, psel && penable && pwrite && pready && paddr == 3'd0,
		prdata[12:0] == $past(pwdata[12:0]))

	`HWCC_ASSERT_IMP(a_chunk_x_sign, m_axis_tvalid, m_axis_tdata[74] == m_axis_tdata[18])

	`HWCC_ASSERT_IMP(a_chunk_y_sign, m_axis_tvalid, m_axis_tdata[93] == m_axis_tdata[37])

endmodule

bind hex_world_to_cell_and_chunk hwcc_checker u_hwcc_checker (.*);
`default_nettype wire
